// ===== hdl/lru_block_cache_with_pending_unit_macros.svh =====
// Assertion macros shared by the LRU block cache RTL.
// Define ASSERT_OFF to compile every check out; no other dependencies.
`ifndef LRU_BLOCK_CACHE_WITH_PENDING_UNIT_MACROS_SVH
`define LRU_BLOCK_CACHE_WITH_PENDING_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Plain property check, disabled during reset.
`define LBC_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// Implication check: consequence must hold in the same cycle.
`define LBC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Implication check: consequence must hold in the next cycle.
`define LBC_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`else

`define LBC_ASSERT(lbl, ck, rs, prop, msg)
`define LBC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define LBC_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)

`endif

`endif

// ===== hdl/lbc_pkg.sv =====
// Shared types and codes for the LRU block cache.
// No dependencies; imported by every module of the block.
package lbc_pkg;

  localparam int LBC_ENTRIES_DEF = 16;
  localparam int FILE_W          = 16;
  localparam int BLOCK_W         = 32;
  localparam int CACHE_BLOCKS_W  = 5;
  localparam int CACHE_BLOCKS_RST = 16;
  localparam int IN_TDATA_W      = 56;
  localparam int OUT_TDATA_W     = 56;

  typedef enum logic [1:0] {
    CMD_READ     = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_NONE     = 2'd3
  } lbc_cmd_e;

  typedef enum logic [2:0] {
    ACT_SERVED    = 3'd0,
    ACT_FORWARD   = 3'd1,
    ACT_QUEUED    = 3'd2,
    ACT_BYPASS    = 3'd3,
    ACT_COALESCED = 3'd4,
    ACT_DONE      = 3'd5,
    ACT_NO_ENTRY  = 3'd6
  } lbc_action_e;

  typedef enum logic {
    REG_CACHE_BLOCKS    = 1'b0,
    REG_FLUSH_IMMEDIATE = 1'b1
  } lbc_reg_e;

  // Cell update operation, broadcast along the row.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_FRONT  = 2'd1,
    OP_INSERT = 2'd2
  } lbc_op_e;

  typedef struct packed {
    logic               valid;
    logic               pend;
    logic [FILE_W-1:0]  file;
    logic [BLOCK_W-1:0] blk;
  } lbc_entry_t;

  typedef struct packed {
    logic    capture;
    lbc_op_e op;
    logic    evict;
  } lbc_cell_ctl_t;

  // Values passed from each cell toward the front of the row.
  typedef struct packed {
    logic       seen;
    logic       allp;
    lbc_entry_t sel;
    lbc_entry_t tail;
  } lbc_chain_t;

endpackage

// ===== hdl/lbc_cell.sv =====
// One recency position of the LRU row: holds an entry, compares its tag
// and shifts from its front neighbor. Depends on lbc_pkg.
module lbc_cell import lbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lbc_cell_ctl_t      ctl,
  input  logic [FILE_W-1:0]  key_file,
  input  logic [BLOCK_W-1:0] key_blk,
  input  lbc_entry_t         prev,
  input  logic               next_valid,
  input  lbc_chain_t         chain_in,
  output lbc_chain_t         chain_out,
  output lbc_entry_t         cur,
  output logic               match
);

  logic               valid;
  logic               pend;
  logic [FILE_W-1:0]  file;
  logic [BLOCK_W-1:0] blk;
  logic               match_q;
  logic               en;

  assign cur   = '{valid: valid, pend: pend, file: file, blk: blk};
  assign match = match_q;

  always_comb begin
    chain_out.seen = chain_in.seen | match_q;
    chain_out.allp = chain_in.allp & (~valid | pend);
    chain_out.sel  = match_q ? cur : chain_in.sel;
    chain_out.tail = (valid && !next_valid) ? cur : chain_in.tail;
  end

  // Shift from the front neighbor: every position up to the hit for a move
  // to front, every occupied position (plus the first free one when not evicting) on insert.
  always_comb begin
    unique case (ctl.op)
      OP_HOLD:   en = 1'b0;
      OP_FRONT:  en = chain_out.seen;
      OP_INSERT: en = ctl.evict ? valid : prev.valid;
      default:   en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctl.capture) begin
        match_q <= valid && (file == key_file) && (blk == key_blk);
      end
      if (en) begin
        valid <= prev.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pend <= prev.pend;
      file <= prev.file;
      blk  <= prev.blk;
    end
  end

endmodule

// ===== hdl/lbc_cfg.sv =====
// APB register file of the LRU block cache and the effective capacity.
// Depends on lbc_pkg.
module lbc_cfg import lbc_pkg::*; #(
  parameter int ENTRIES = LBC_ENTRIES_DEF,
  parameter int CAPW    = ($clog2(ENTRIES + 1) > CACHE_BLOCKS_W) ?
                          $clog2(ENTRIES + 1) : CACHE_BLOCKS_W
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output logic [CAPW-1:0] cap,
  output logic            flush_immediate
);

  logic [CACHE_BLOCKS_W-1:0] cache_blocks;
  lbc_reg_e                  idx;
  logic [CAPW-1:0]           cb_ext;

  assign pready = 1'b1;
  assign idx    = lbc_reg_e'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_blocks    <= CACHE_BLOCKS_W'(CACHE_BLOCKS_RST);
      flush_immediate <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_CACHE_BLOCKS:    cache_blocks    <= pwdata[CACHE_BLOCKS_W-1:0];
        REG_FLUSH_IMMEDIATE: flush_immediate <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CACHE_BLOCKS:    prdata = 32'(cache_blocks);
      REG_FLUSH_IMMEDIATE: prdata = 32'(flush_immediate);
      default:             prdata = '0;
    endcase
  end

  // Zero acts as one, anything above the row length as the row length.
  always_comb begin
    cb_ext = CAPW'(cache_blocks);
    if (cb_ext == '0) begin
      cap = CAPW'(1);
    end else if (cb_ext > CAPW'(ENTRIES)) begin
      cap = CAPW'(ENTRIES);
    end else begin
      cap = cb_ext;
    end
  end

endmodule

// ===== hdl/lru_block_cache_with_pending_unit.sv =====
// Top level of the LRU block cache with pending marks: request stream in,
// result stream out, APB registers. Depends on lbc_pkg, lbc_cell, lbc_cfg.
//
//   port group        | dir | width | carries
//   s_tvalid/tready   | in  | 56    | command, file_id, block_index
//   m_tvalid/tready   | out | 56    | action, hit, evicted, evicted_file,
//                     |     |       | evicted_block, flush_now
//   psel..pready      | in  | 32    | cache_blocks, flush_immediate
//
// For each request, the tag compare in every cell is registered at accept,
// then the chain of cells resolves hit, tail and pending state and the row
// shifts while the result is written to the output register.
// A new request is taken the cycle after that, also while a result still
// waits in the output register; only a full output register stalls the step.
// Reset (rst, synchronous) empties the row and loads the register defaults.
`include "lru_block_cache_with_pending_unit_macros.svh"

module lru_block_cache_with_pending_unit import lbc_pkg::*; #(
  parameter int ENTRIES = LBC_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // command [1:0], file_id [17:2], block_index [49:18], zero pad above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // action [2:0], hit [3], evicted [4], evicted_file [20:5],
  // evicted_block [52:21], flush_now [53], zero pad above
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CAPW = (CW > CACHE_BLOCKS_W) ? CW : CACHE_BLOCKS_W;

  // Configuration
  logic [CAPW-1:0] cap;
  logic            flush_immediate;

  lbc_cfg #(.ENTRIES(ENTRIES), .CAPW(CAPW)) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .cap             (cap),
    .flush_immediate (flush_immediate)
  );

  // Request held until the resolve step
  logic               a_valid;
  lbc_cmd_e           a_cmd;
  logic [FILE_W-1:0]  a_file;
  logic [BLOCK_W-1:0] a_blk;
  logic [CW-1:0]      count;

  logic accept;
  logic do_step;

  assign s_tready = ~a_valid;
  assign accept   = s_tvalid & s_tready;
  assign do_step  = a_valid & (~m_tvalid | m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (do_step) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cmd  <= lbc_cmd_e'(s_tdata[1:0]);
      a_file <= s_tdata[17:2];
      a_blk  <= s_tdata[49:18];
    end
  end

  // Row of cells; position 0 is the most recent entry
  lbc_cell_ctl_t ctl;
  lbc_entry_t    head;
  lbc_entry_t    cur   [ENTRIES];
  lbc_chain_t    chain [ENTRIES+1];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;

  assign chain[ENTRIES] = '{seen: 1'b0, allp: 1'b1, sel: '0, tail: '0};

  for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
    lbc_entry_t prev_e;
    logic       nxt_v;

    if (p == 0) begin : g_front
      assign prev_e = head;
    end else begin : g_inner
      assign prev_e = cur[p-1];
    end

    if (p == ENTRIES - 1) begin : g_last
      assign nxt_v = 1'b0;
    end else begin : g_mid
      assign nxt_v = cur[p+1].valid;
    end

    lbc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key_file   (s_tdata[17:2]),
      .key_blk    (s_tdata[49:18]),
      .prev       (prev_e),
      .next_valid (nxt_v),
      .chain_in   (chain[p+1]),
      .chain_out  (chain[p]),
      .cur        (cur[p]),
      .match      (match_vec[p])
    );

    assign valid_vec[p] = cur[p].valid;
  end

  // Resolve: decide the action and the row operation
  logic          hit;
  lbc_entry_t    hit_e;
  lbc_entry_t    tail_e;
  logic          full;
  logic          allpend;
  logic          bypass;
  logic [CW-1:0] count_inc;
  lbc_op_e       op;
  logic          evict;
  logic          emit;
  lbc_action_e   act;
  logic          flush;

  assign hit       = chain[0].seen;
  assign hit_e     = chain[0].sel;
  assign tail_e    = chain[0].tail;
  assign full      = CAPW'(count) >= cap;
  assign allpend   = chain[0].allp && (count != '0);
  assign bypass    = full && allpend && !hit;
  assign count_inc = count + CW'(1);

  always_comb begin
    op    = OP_HOLD;
    evict = 1'b0;
    emit  = 1'b1;
    act   = ACT_SERVED;
    flush = 1'b0;
    head  = hit_e;
    head.valid = 1'b1;
    unique case (a_cmd)
      CMD_COMPLETE: begin
        if (hit) begin
          op        = OP_FRONT;
          head.pend = 1'b0;
          act       = ACT_DONE;
        end else begin
          act = ACT_NO_ENTRY;
        end
      end
      CMD_READ: begin
        if (bypass) begin
          act = ACT_BYPASS;
        end else if (hit) begin
          act = ACT_SERVED;
          // a pending block keeps its place
          if (!hit_e.pend) begin
            op = OP_FRONT;
          end
        end else begin
          op    = OP_INSERT;
          evict = full && (count != '0);
          act   = ACT_FORWARD;
          head  = '{valid: 1'b1, pend: 1'b1, file: a_file, blk: a_blk};
        end
      end
      CMD_WRITE: begin
        if (bypass) begin
          act = ACT_BYPASS;
        end else if (hit) begin
          if (hit_e.pend) begin
            act = ACT_COALESCED;
          end else begin
            op        = OP_FRONT;
            head.pend = 1'b1;
            act       = ACT_QUEUED;
            flush     = full || flush_immediate;
          end
        end else begin
          op    = OP_INSERT;
          evict = full && (count != '0);
          act   = ACT_QUEUED;
          head  = '{valid: 1'b1, pend: 1'b1, file: a_file, blk: a_blk};
          flush = (CAPW'(evict ? count : count_inc) >= cap) || flush_immediate;
        end
      end
      default: begin
        // unknown command: drop it, no result
        emit = 1'b0;
      end
    endcase
  end

  assign ctl = '{capture: accept, op: (do_step ? op : OP_HOLD), evict: evict};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_step && (op == OP_INSERT) && !evict) begin
      count <= count_inc;
    end
  end

  // Output register
  lbc_action_e        o_act;
  logic               o_hit;
  logic               o_evict;
  logic [FILE_W-1:0]  o_efile;
  logic [BLOCK_W-1:0] o_eblk;
  logic               o_flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_step && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step && emit) begin
      o_act   <= act;
      o_hit   <= hit;
      o_evict <= evict && (op == OP_INSERT);
      o_efile <= (evict && (op == OP_INSERT)) ? tail_e.file : '0;
      o_eblk  <= (evict && (op == OP_INSERT)) ? tail_e.blk : '0;
      o_flush <= flush;
    end
  end

  assign m_tdata = {2'b00, o_flush, o_eblk, o_efile, o_evict, o_hit, o_act};

  // Checks
  `LBC_ASSERT(a_unique_match, clk, rst, $onehot0(match_vec), "more than one cell matched the tag")
  `LBC_ASSERT(a_count_valid, clk, rst, $countones(valid_vec) == count, "occupied cells disagree with count")
  `LBC_ASSERT_NXT(a_insert_grows, clk, rst, do_step && (op == OP_INSERT) && !evict, count == $past(count) + CW'(1), "insert without eviction did not grow the count")
  `LBC_ASSERT_IMP(a_evict_kind, clk, rst, m_tvalid && o_evict, (o_act == ACT_FORWARD) || (o_act == ACT_QUEUED), "eviction reported on a request that does not insert")

endmodule
